[rtl/m3i_pkg.sv]
package m3i_pkg;

   localparam int ELEM_W     = 32;
   localparam int TAG_W      = 4;
   localparam int INV_W      = 48;
   localparam int VOL_W      = 64;
   localparam int PROD_W     = 2 * ELEM_W;
   localparam int ADJ_W      = PROD_W + 1;
   localparam int PART_W     = ADJ_W;
   localparam int DET_W      = 97;
   localparam int VOL_SHIFT  = 16;
   localparam int Q_BITS     = INV_W + 1;
   localparam int DIV_LAT    = Q_BITS + 2;
   localparam int PRE_STAGES = 5;
   localparam int NSTAGE     = PRE_STAGES + DIV_LAT;
   localparam int N_ELEM     = 9;
   localparam int N_ROW      = 3;

   localparam logic [Q_BITS-1:0] INV_PMAX = Q_BITS'((64'd1 << (INV_W - 1)) - 64'd1);
   localparam logic [Q_BITS-1:0] INV_NMAG = Q_BITS'(64'd1 << (INV_W - 1));

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef logic signed [INV_W-1:0]  inv_type;

   typedef struct packed {
      logic [TAG_W-1:0] box_index;
      elem_type         m00;
      elem_type         m01;
      elem_type         m02;
      elem_type         m10;
      elem_type         m11;
      elem_type         m12;
      elem_type         m20;
      elem_type         m21;
      elem_type         m22;
   } req_type;

   typedef struct packed {
      logic [TAG_W-1:0]        box_tag;
      inv_type                 inv00;
      inv_type                 inv01;
      inv_type                 inv02;
      inv_type                 inv10;
      inv_type                 inv11;
      inv_type                 inv12;
      inv_type                 inv20;
      inv_type                 inv21;
      inv_type                 inv22;
      logic signed [VOL_W-1:0] volume;
      logic                    singular;
   } rsp_type;

   typedef struct packed {
      logic [DET_W-1:0]  rem;
      logic [DET_W-1:0]  dvs;
      logic [Q_BITS-1:0] nbits;
      logic [Q_BITS-1:0] quo;
      logic              ovf;
      logic              neg;
   } div_type;

endpackage

[rtl/m3i_cofactor.sv]
module m3i_cofactor (
   input  logic                              clock,
   input  logic [1:0]                        adv,
   input  m3i_pkg::elem_type                 a,
   input  m3i_pkg::elem_type                 b,
   input  m3i_pkg::elem_type                 c,
   input  m3i_pkg::elem_type                 d,
   output logic signed [m3i_pkg::ADJ_W-1:0]  adj
);
   import m3i_pkg::*;

   logic signed [PROD_W-1:0] pab_ff, pcd_ff;
   logic signed [ADJ_W-1:0]  adj_ff;

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         pab_ff <= a * b;
         pcd_ff <= c * d;
      end
      if (adv[1]) begin
         adj_ff <= ADJ_W'(pab_ff) - ADJ_W'(pcd_ff);
      end
   end

   assign adj = adj_ff;

endmodule

[rtl/m3i_divider.sv]
module m3i_divider (
   input  logic                               clock,
   input  logic [m3i_pkg::DIV_LAT-1:0]        adv,
   input  logic signed [m3i_pkg::ADJ_W-1:0]   adj,
   input  logic signed [m3i_pkg::DET_W-1:0]   det,
   output m3i_pkg::inv_type                   quo
);
   import m3i_pkg::*;

   div_type          st_ff [Q_BITS+1];
   div_type          st_in [Q_BITS+1];
   logic [DET_W:0]   trial [Q_BITS+1];
   logic [ADJ_W-1:0] adj_mag;
   logic [DET_W-1:0] det_mag;
   div_type          last;
   inv_type          res_in, res_ff;

   always_comb begin
      adj_mag = adj[ADJ_W-1] ? ADJ_W'(-adj) : adj;
      det_mag = det[DET_W-1] ? DET_W'(-det) : det;
      st_in[0].rem   = DET_W'(adj_mag >> 1);
      st_in[0].dvs   = det_mag;
      st_in[0].nbits = {adj_mag[0], (Q_BITS-1)'(0)};
      st_in[0].quo   = '0;
      st_in[0].ovf   = DET_W'(adj_mag >> 1) >= det_mag;
      st_in[0].neg   = adj[ADJ_W-1] ^ det[DET_W-1];
      trial[0] = '0;
      for (int k = 1; k <= Q_BITS; k++) begin
         trial[k] = {st_ff[k-1].rem, st_ff[k-1].nbits[Q_BITS-1]};
         st_in[k] = st_ff[k-1];
         st_in[k].nbits = st_ff[k-1].nbits << 1;
         if (trial[k] >= {1'b0, st_ff[k-1].dvs}) begin
            st_in[k].rem = DET_W'(trial[k] - {1'b0, st_ff[k-1].dvs});
            st_in[k].quo = {st_ff[k-1].quo[Q_BITS-2:0], 1'b1};
         end else begin
            st_in[k].rem = DET_W'(trial[k]);
            st_in[k].quo = {st_ff[k-1].quo[Q_BITS-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      last = st_ff[Q_BITS];
      if (!last.neg) begin
         res_in = (last.ovf || last.quo > INV_PMAX) ? INV_W'(INV_PMAX) : INV_W'(last.quo);
      end else begin
         res_in = (last.ovf || last.quo > INV_NMAG) ? INV_W'(INV_NMAG)
                                                     : INV_W'(-INV_W'(last.quo));
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= Q_BITS; k++) begin
         if (adv[k]) begin
            st_ff[k] <= st_in[k];
         end
      end
      if (adv[DIV_LAT-1]) begin
         res_ff <= res_in;
      end
   end

   assign quo = res_ff;

endmodule

[rtl/matrix3x3_inverse_determinant.sv]
// Channel   Ports              Content
// request   req_valid/ready    req_data: box_index, m00..m22 (Q16.16)
// response  rsp_valid/ready    rsp_data: box_tag, inv00..inv22 (Q16.32), volume, singular
//
// One request per cycle sustained while rsp_ready stays high; rsp_valid rises once the request reaches the last stage.
// Latency is set by the nine 49-step restoring divider pipelines, one quotient bit per stage.
// Every stage advances on its own when the next one is empty or moving, so bubbles close
// up and requests are taken while a response waits. reset (synchronous) empties the pipeline.
module matrix3x3_inverse_determinant (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  m3i_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output m3i_pkg::rsp_type rsp_data
);
   import m3i_pkg::*;

   localparam int COF_A [N_ELEM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
   localparam int COF_B [N_ELEM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
   localparam int COF_C [N_ELEM] = '{7, 1, 2, 3, 2, 0, 4, 0, 1};
   localparam int COF_D [N_ELEM] = '{5, 8, 4, 8, 6, 5, 6, 7, 3};

   logic [NSTAGE-1:0]       vld_ff, vld_in;
   logic [NSTAGE:0]         adv;
   elem_type                m [N_ELEM];
   elem_type                col_in [N_ROW];
   elem_type                col_ff [2][N_ROW];
   logic [TAG_W-1:0]        tag_ff [NSTAGE];
   logic signed [ADJ_W-1:0] adj1 [N_ELEM];
   logic signed [ADJ_W-1:0] adjc_ff [2:PRE_STAGES-1][N_ELEM];
   logic signed [PART_W-1:0] lo_ff [N_ROW];
   logic signed [PART_W-1:0] hi_ff [N_ROW];
   logic signed [DET_W-1:0] prod_ff [N_ROW];
   logic signed [DET_W-1:0] det_ff;
   logic [DET_W-VOL_SHIFT-1:0] vsh;
   logic signed [VOL_W-1:0] vol_in;
   logic signed [VOL_W-1:0] vol_ff [PRE_STAGES:NSTAGE-1];
   logic                    sing_ff [PRE_STAGES:NSTAGE-1];
   inv_type                 q [N_ELEM];
   inv_type                 inv [N_ELEM];

   always_comb begin
      adv[NSTAGE] = rsp_ready;
      for (int k = NSTAGE - 1; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
      vld_in = {vld_ff[NSTAGE-2:0], req_valid};
   end

   assign req_ready = adv[0];
   assign rsp_valid = vld_ff[NSTAGE-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NSTAGE; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   always_comb begin
      m[0] = req_data.m00;
      m[1] = req_data.m01;
      m[2] = req_data.m02;
      m[3] = req_data.m10;
      m[4] = req_data.m11;
      m[5] = req_data.m12;
      m[6] = req_data.m20;
      m[7] = req_data.m21;
      m[8] = req_data.m22;
      for (int r = 0; r < N_ROW; r++) begin
         col_in[r] = m[N_ROW*r];
      end
   end

   for (genvar g = 0; g < N_ELEM; g++) begin : g_cof
      m3i_cofactor u_cof (
         .clock (clock),
         .adv   (adv[1:0]),
         .a     (m[COF_A[g]]),
         .b     (m[COF_B[g]]),
         .c     (m[COF_C[g]]),
         .d     (m[COF_D[g]]),
         .adj   (adj1[g])
      );
   end

   always_comb begin
      vsh = det_ff[DET_W-1:VOL_SHIFT];
      if (&vsh[DET_W-VOL_SHIFT-1:VOL_W-1] || ~|vsh[DET_W-VOL_SHIFT-1:VOL_W-1]) begin
         vol_in = vsh[VOL_W-1:0];
      end else begin
         vol_in = det_ff[DET_W-1] ? {1'b1, (VOL_W-1)'(0)} : {1'b0, {(VOL_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         tag_ff[0] <= req_data.box_index;
         col_ff[0] <= col_in;
      end
      for (int k = 1; k < NSTAGE; k++) begin
         if (adv[k]) begin
            tag_ff[k] <= tag_ff[k-1];
         end
      end
      if (adv[1]) begin
         col_ff[1] <= col_ff[0];
      end
      if (adv[2]) begin
         adjc_ff[2] <= adj1;
         for (int r = 0; r < N_ROW; r++) begin
            lo_ff[r] <= $signed({1'b0, adj1[r][ELEM_W-1:0]}) * col_ff[1][r];
            hi_ff[r] <= $signed(adj1[r][ADJ_W-1:ELEM_W]) * col_ff[1][r];
         end
      end
      if (adv[3]) begin
         adjc_ff[3] <= adjc_ff[2];
         for (int r = 0; r < N_ROW; r++) begin
            prod_ff[r] <= (DET_W'(hi_ff[r]) <<< ELEM_W) + DET_W'(lo_ff[r]);
         end
      end
      if (adv[4]) begin
         adjc_ff[4] <= adjc_ff[3];
         det_ff     <= prod_ff[0] + prod_ff[1] + prod_ff[2];
      end
      if (adv[PRE_STAGES]) begin
         vol_ff[PRE_STAGES]  <= vol_in;
         sing_ff[PRE_STAGES] <= (det_ff == '0);
      end
      for (int k = PRE_STAGES + 1; k < NSTAGE; k++) begin
         if (adv[k]) begin
            vol_ff[k]  <= vol_ff[k-1];
            sing_ff[k] <= sing_ff[k-1];
         end
      end
   end

   for (genvar g = 0; g < N_ELEM; g++) begin : g_div
      m3i_divider u_div (
         .clock (clock),
         .adv   (adv[NSTAGE-1:PRE_STAGES]),
         .adj   (adjc_ff[PRE_STAGES-1][g]),
         .det   (det_ff),
         .quo   (q[g])
      );
   end

   always_comb begin
      for (int e = 0; e < N_ELEM; e++) begin
         inv[e] = sing_ff[NSTAGE-1] ? '0 : q[e];
      end
      rsp_data.box_tag  = tag_ff[NSTAGE-1];
      rsp_data.inv00    = inv[0];
      rsp_data.inv01    = inv[1];
      rsp_data.inv02    = inv[2];
      rsp_data.inv10    = inv[3];
      rsp_data.inv11    = inv[4];
      rsp_data.inv12    = inv[5];
      rsp_data.inv20    = inv[6];
      rsp_data.inv21    = inv[7];
      rsp_data.inv22    = inv[8];
      rsp_data.volume   = vol_ff[NSTAGE-1];
      rsp_data.singular = sing_ff[NSTAGE-1];
   end

   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.singular |-> rsp_data.volume == '0 && rsp_data.inv00 == '0
         && rsp_data.inv22 == '0)
      else $error("singular response with nonzero fields");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vld_ff[0])
      else $error("accepted request missing from first stage");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (&vld_ff) && !rsp_ready |-> !req_ready)
      else $error("request taken into a full stalled pipeline");

   a_stage_move: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] && adv[1] |=> vld_ff[1])
      else $error("request lost between first and second stage");

endmodule

[tb/tb.sv]
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import m3i_pkg::*;

   class inverse_board;
      rsp_type pending[$];
      int      errors;
      int      checked;
      int      singulars;

      function automatic logic signed [47:0] inv_of(logic signed [64:0] adj,
                                                    logic signed [96:0] det);
         logic [64:0]  amag;
         logic [96:0]  dmag;
         logic [127:0] num;
         logic [127:0] quo;
         logic         neg;
         amag = adj[64] ? 65'(-adj) : 65'(adj);
         dmag = det[96] ? 97'(-det) : 97'(det);
         num  = {63'd0, amag} << 48;
         quo  = num / {31'd0, dmag};
         neg  = adj[64] != det[96];
         if (!neg) begin
            if (quo > 128'h7FFF_FFFF_FFFF) return 48'h7FFF_FFFF_FFFF;
            return quo[47:0];
         end
         if (quo > 128'h8000_0000_0000) return 48'h8000_0000_0000;
         return 48'(-quo[47:0]);
      endfunction

      function automatic rsp_type solve_inverse(req_type r);
         logic signed [64:0]  a[9];
         logic signed [64:0]  adj[9];
         logic signed [96:0]  det;
         logic signed [96:0]  vol;
         rsp_type             o;
         a[0] = r.m00; a[1] = r.m01; a[2] = r.m02;
         a[3] = r.m10; a[4] = r.m11; a[5] = r.m12;
         a[6] = r.m20; a[7] = r.m21; a[8] = r.m22;
         adj[0] = a[4] * a[8] - a[7] * a[5];
         adj[1] = a[2] * a[7] - a[1] * a[8];
         adj[2] = a[1] * a[5] - a[2] * a[4];
         adj[3] = a[5] * a[6] - a[3] * a[8];
         adj[4] = a[0] * a[8] - a[2] * a[6];
         adj[5] = a[2] * a[3] - a[0] * a[5];
         adj[6] = a[3] * a[7] - a[4] * a[6];
         adj[7] = a[1] * a[6] - a[0] * a[7];
         adj[8] = a[0] * a[4] - a[1] * a[3];
         det = 97'(adj[0]) * 97'(a[0]) + 97'(adj[1]) * 97'(a[3])
             + 97'(adj[2]) * 97'(a[6]);
         o = '0;
         o.box_tag  = r.box_index;
         o.singular = det == 0;
         if (!o.singular) begin
            o.inv00 = inv_of(adj[0], det); o.inv01 = inv_of(adj[1], det);
            o.inv02 = inv_of(adj[2], det); o.inv10 = inv_of(adj[3], det);
            o.inv11 = inv_of(adj[4], det); o.inv12 = inv_of(adj[5], det);
            o.inv20 = inv_of(adj[6], det); o.inv21 = inv_of(adj[7], det);
            o.inv22 = inv_of(adj[8], det);
         end
         vol = det >>> 16;
         if (vol > 97'sh7FFF_FFFF_FFFF_FFFF) o.volume = 64'h7FFF_FFFF_FFFF_FFFF;
         else if (vol < -97'sh8000_0000_0000_0000) o.volume = 64'h8000_0000_0000_0000;
         else o.volume = vol[63:0];
         return o;
      endfunction

      function void note_request(req_type r);
         pending.push_back(solve_inverse(r));
      endfunction

      function void check_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $error("%s expected %h actual %h", name, want, got);
            errors++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type w;
         if (pending.size() == 0) begin
            $error("response with none expected");
            errors++;
            return;
         end
         w = pending.pop_front();
         checked++;
         if (w.singular) singulars++;
         check_field("box_tag", w.box_tag, got.box_tag);
         check_field("inv00", w.inv00, got.inv00);
         check_field("inv01", w.inv01, got.inv01);
         check_field("inv02", w.inv02, got.inv02);
         check_field("inv10", w.inv10, got.inv10);
         check_field("inv11", w.inv11, got.inv11);
         check_field("inv12", w.inv12, got.inv12);
         check_field("inv20", w.inv20, got.inv20);
         check_field("inv21", w.inv21, got.inv21);
         check_field("inv22", w.inv22, got.inv22);
         check_field("volume", w.volume, got.volume);
         check_field("singular", w.singular, got.singular);
      endfunction
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 0;
   rsp_type rsp_data;

   inverse_board board = new();
   int  send_idle = 0;
   int  recv_stall = 0;
   int  hold_off = 0;
   int  cycles = 0;
   bit  sent_all = 0;

   always #5 clock = ~clock;

   matrix3x3_inverse_determinant u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("DONE: errors detected");
         $finish;
      end
      if (!reset && req_valid && req_ready) board.note_request(req_data);
      if (!reset && rsp_valid && rsp_ready) board.check_response(rsp_data);
   end

   always @(negedge clock) begin
      if (hold_off > 0) begin
         rsp_ready <= 0;
         hold_off  <= hold_off - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall);
      end
   end

   function automatic logic [31:0] pick_elem();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'(signed'($urandom_range(8)) - 4) << 16;
         3: return 32'($urandom_range(3)) - 1;
         4: return $urandom_range(65535) << $urandom_range(16);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_request(req_type r);
      req_valid <= 1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         req_data  <= req_type'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                 $urandom, $urandom, $urandom, $urandom, $urandom});
         do @(negedge clock); while ($urandom_range(99) < send_idle);
      end
   endtask

   task automatic send_matrix(logic [3:0] tag, logic [31:0] m[9]);
      req_type r;
      r = {tag, m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]};
      send_request(r);
   endtask

   task automatic send_random();
      logic [31:0] m[9];
      int kind;
      kind = $urandom_range(9);
      for (int i = 0; i < 9; i++) m[i] = pick_elem();
      if (kind == 0) for (int i = 0; i < 3; i++) m[6 + i] = m[i];
      if (kind == 1) for (int i = 0; i < 3; i++) m[3 * i + 2] = 0;
      if (kind == 2) begin
         m[1] = 0; m[2] = 0; m[3] = 0; m[5] = 0; m[6] = 0; m[7] = 0;
      end
      send_matrix(4'($urandom), m);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
   endtask

   initial begin
      logic [31:0] m[9];
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      m = '{32'h1_0000, 0, 0, 0, 32'h1_0000, 0, 0, 0, 32'h1_0000};
      send_matrix(4'd0, m);
      m = '{32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF};
      send_matrix(4'd15, m);
      m = '{32'h8000_0000, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 32'h8000_0000};
      send_matrix(4'd9, m);
      m = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
            32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'hFFFF_FFFF, 32'h1234_5678};
      send_matrix(4'd5, m);
      m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
      send_matrix(4'd3, m);
      m = '{32'h1_0000, 32'h2_0000, 32'h3_0000, 32'h2_0000, 32'h4_0000,
            32'h6_0000, 32'h7_0000, 32'h8_0000, 32'h9_0000};
      send_matrix(4'd7, m);
      m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
      send_matrix(4'd12, m);
      m = '{32'hFFFF_FFFF, 0, 0, 0, 1, 0, 0, 0, 1};
      send_matrix(4'd1, m);
      m = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
      send_matrix(4'd10, m);
      m = '{32'h0, 32'h1_0000, 32'h0, 32'h0, 32'h0, 32'h1_0000, 32'h1_0000, 0, 0};
      send_matrix(4'd14, m);

      for (int phase = 0; phase < 4; phase++) begin
         send_idle  = (phase == 1 || phase == 3) ? (phase == 1 ? 46 : 33) : 0;
         recv_stall = (phase == 2 || phase == 3) ? (phase == 2 ? 46 : 33) : 0;
         if (phase == 0) hold_off = 300;
         for (int n = 0; n < 450; n++) send_random();
         drain();
      end
      send_idle  = 0;
      recv_stall = 0;
      repeat (120) @(posedge clock);
      $display("checked %0d inverse responses, %0d singular, under four handshake mixes",
               board.checked, board.singulars);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

[matrix3x3_inverse_determinant.f]
rtl/m3i_pkg.sv
rtl/m3i_cofactor.sv
rtl/m3i_divider.sv
rtl/matrix3x3_inverse_determinant.sv
tb/tb.sv
